[rtl/ifrd_pkg.sv]
package ifrd_pkg;

    localparam int MAX_FRAME = 4096;
    localparam int COUNT_W   = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic [7:0] CTRL_SEQ1 = 8'h80;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_SUB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_SUB  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SEQ_ERR  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_ADDR = 5'b00010,
        PH_CTRL = 5'b00100,
        PH_HCS  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] escape_byte;
        logic [7:0] flag_substitute;
        logic [7:0] escape_substitute;
        logic [7:0] address_byte;
    } cfg_t;

    typedef struct packed {
        logic             received_seq;
        logic [1:0]       status;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       payload_byte;
        logic             kind;
    } result_t;

endpackage

[rtl/ifrd_cfg_regs.sv]
module ifrd_cfg_regs
    import ifrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]           wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_FLAG:     cfg_next.flag_byte         = wr_data;
                CFG_ESCAPE:   cfg_next.escape_byte       = wr_data;
                CFG_FLAG_SUB: cfg_next.flag_substitute   = wr_data;
                CFG_ESC_SUB:  cfg_next.escape_substitute = wr_data;
                CFG_ADDRESS:  cfg_next.address_byte      = wr_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.flag_byte         <= 8'h7E;
            cfg_reg.escape_byte       <= 8'h7D;
            cfg_reg.flag_substitute   <= 8'h5E;
            cfg_reg.escape_substitute <= 8'h5D;
            cfg_reg.address_byte      <= 8'h03;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ifrd_parser.sv]
module ifrd_parser
    import ifrd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] line_byte,
    input  logic       expected_seq,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t             phase_reg, phase_next;
    logic               esc_reg, esc_next;
    logic               seq_reg, seq_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               emit;
    logic [7:0]         emit_byte;
    logic [7:0]         hcs_expect;

    assign hcs_expect = cfg.address_byte ^ (seq_reg ? CTRL_SEQ1 : CTRL_SEQ0);

    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        emit       = 1'b0;
        emit_byte  = line_byte;
        res_valid  = 1'b0;
        res        = '0;

        if (phase_reg == PH_DATA && esc_reg) begin
            // second byte of a stuffed pair; unknown substitutes are dropped
            if (line_byte == cfg.flag_substitute) begin
                esc_next  = 1'b0;
                emit      = 1'b1;
                emit_byte = cfg.flag_byte;
            end else if (line_byte == cfg.escape_substitute) begin
                esc_next  = 1'b0;
                emit      = 1'b1;
                emit_byte = cfg.escape_byte;
            end
        end else begin
            unique case (phase_reg)
                PH_ADDR: begin
                    if (line_byte == cfg.address_byte) begin
                        phase_next = PH_CTRL;
                    end else if (line_byte != cfg.flag_byte) begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CTRL: begin
                    if (line_byte == CTRL_SEQ0 || line_byte == CTRL_SEQ1) begin
                        seq_next   = line_byte[7];
                        phase_next = PH_HCS;
                    end else if (line_byte == cfg.flag_byte) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_HCS: begin
                    if (line_byte == hcs_expect) begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        ovf_next   = 1'b0;
                        esc_next   = 1'b0;
                    end else if (line_byte == cfg.flag_byte) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA: begin
                    if (line_byte == cfg.flag_byte) begin
                        res_valid        = 1'b1;
                        res.kind         = KIND_REPORT;
                        res.frame_length = LEN_W'(count_reg);
                        res.received_seq = seq_reg;
                        if (ovf_reg) begin
                            res.status = ST_OVERFLOW;
                        end else if (seq_reg != expected_seq) begin
                            res.status = ST_SEQ_ERR;
                        end else begin
                            res.status = ST_OK;
                        end
                        phase_next = PH_HUNT;
                        esc_next   = 1'b0;
                    end else if (line_byte == cfg.escape_byte) begin
                        esc_next = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: begin
                    phase_next = (line_byte == cfg.flag_byte) ? PH_ADDR : PH_HUNT;
                end
            endcase
        end

        if (emit) begin
            if (count_reg >= COUNT_W'(MAX_FRAME)) begin
                ovf_next = 1'b1;
            end else begin
                count_next       = count_reg + 1'b1;
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = emit_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            esc_reg   <= 1'b0;
            seq_reg   <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[rtl/ifrd_out_buf.sv]
module ifrd_out_buf
    import ifrd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end else if (in_valid) begin
            // output stalled: park the new result
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/info_frame_receiver_destuff.sv]
// Information frame receiver with byte destuffing. One line byte is taken per
// request on the s_ channel (tdata = line byte, tuser = expected sequence bit)
// and handled in the cycle it is accepted; a payload byte or an end-of-frame
// report is registered on its way to m_. Sustained rate is one byte per clock
// while m_tready is high: the result register and a one-entry skid stage let
// input flow on while a result waits; s_tready drops only when both hold one.
// Registers are written through the cfg_ port (0 flag, 1 escape, 2 flag
// substitute, 3 escape substitute, 4 address); write them only while idle.
module info_frame_receiver_destuff
    import ifrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] line_byte
    input  logic                 s_tuser,   // [0] expected_seq

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [7:0] payload_byte, [20:8] frame_length,
                                            // [22:21] status, [23] received_seq
    output logic                 m_tuser,   // [0] kind

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t    cfg;
    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_res;
    logic    buf_ready;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_ready;
    assign accept    = s_tvalid && buf_ready;

    ifrd_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ifrd_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .line_byte    (s_tdata),
        .expected_seq (s_tuser),
        .cfg          (cfg),
        .res_valid    (res_valid),
        .res          (res)
    );

    ifrd_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_data   (res),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_res.received_seq, out_res.status, out_res.frame_length,
                      out_res.payload_byte};
    assign m_tuser = out_res.kind;

endmodule
